// ===== sv/ctsq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsq_pkg
// Types and constants shared by the collider table query block.
// ----------------------------------------------------------------------------
package ctsq_pkg;

    localparam int HANDLE_W = 6;
    localparam int MAX_HITS = 64;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_ADD   = 3'd1,
        OP_REM   = 3'd2,
        OP_SETP  = 3'd3,
        OP_GETP  = 3'd4,
        OP_QUERY = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_INACT  = 2'd2,
        ST_NOHIT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SH_BOX     = 2'd0,
        SH_SPHERE  = 2'd1,
        SH_CAPSULE = 2'd2
    } shape_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_ADD,
        S_RDWAIT,
        S_OP,
        S_QRD,
        S_QTEST,
        S_OUT,
        S_QEND
    } state_t;

    typedef struct packed {
        logic clear_all;
        logic scan_start;
        logic scan_step;
        logic add_write;
        logic rd_issue;
        logic do_remove;
        logic do_setp;
        logic q_start;
        logic q_step;
        logic res_load;
        logic res_nohit;
        logic res_hit;
    } cmd_t;

    typedef struct packed {
        logic scan_free;
        logic scan_done;
        logic q_hit;
        logic q_done;
        logic any_hit;
        logic pend_hit;
    } sts_t;

endpackage

// ===== sv/ctsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctsq_ctrl
// Controller state machine sequencing table operations and queries.
// ----------------------------------------------------------------------------
module ctsq_ctrl import ctsq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  opcode_t    op,
    input  logic       out_busy,
    input  logic       out_fire,
    input  sts_t       sts,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (op)
                        OP_CLEAR: begin
                            cmd.clear_all = 1'b1;
                            state_next = S_OUT;
                        end
                        OP_ADD: begin
                            cmd.scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        OP_REM, OP_SETP, OP_GETP: begin
                            cmd.rd_issue = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        OP_QUERY: begin
                            cmd.q_start = 1'b1;
                            state_next = S_QRD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (sts.scan_free) begin
                    cmd.add_write = 1'b1;
                    state_next = S_OUT;
                end else if (sts.scan_done) begin
                    cmd.add_write = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RDWAIT: state_next = S_OP;
            S_OP: begin
                cmd.do_remove = (op == OP_REM);
                cmd.do_setp = (op == OP_SETP);
                cmd.res_load = 1'b1;
                state_next = S_OUT;
            end
            S_QRD: begin
                if (sts.q_done) begin
                    state_next = S_QEND;
                end else begin
                    state_next = S_QTEST;
                end
            end
            S_QTEST: begin
                if (sts.q_hit && sts.pend_hit && out_busy) begin
                    state_next = S_QTEST;
                end else begin
                    cmd.q_step = 1'b1;
                    cmd.res_hit = sts.q_hit;
                    state_next = S_QRD;
                end
            end
            S_QEND: begin
                if (!out_busy) begin
                    if (sts.any_hit) begin
                        cmd.res_load = 1'b1;
                    end else begin
                        cmd.res_nohit = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_busy || out_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/ctsq_dp.sv =====
// ----------------------------------------------------------------------------
// ctsq_dp
// Datapath: entry memory, slot scan, overlap test and result register.
// ----------------------------------------------------------------------------
module ctsq_dp import ctsq_pkg::*; #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 24,
    parameter int LAYER_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic [2:0]                   in_op,
    input  logic [5:0]                   in_slot,
    input  logic [1:0]                   in_shape,
    input  logic signed [COORD_BITS-1:0] in_px,
    input  logic signed [COORD_BITS-1:0] in_py,
    input  logic signed [COORD_BITS-1:0] in_pz,
    input  logic [COORD_BITS-2:0]        in_ex,
    input  logic [COORD_BITS-2:0]        in_ey,
    input  logic [COORD_BITS-2:0]        in_ez,
    input  logic [LAYER_BITS-1:0]        in_layer,
    input  logic [LAYER_BITS-1:0]        in_mask,
    input  logic [6:0]                   in_limit,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    output opcode_t                      op,
    input  logic                         out_fire,
    output logic                         out_valid,
    output logic [5:0]                   out_handle,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [1:0]                   out_status,
    output logic                         out_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS - 1;
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW + 2;
    localparam int RECW = 2 + 3 * CW + 3 * EW + 2 * LAYER_BITS;

    logic [SLOTS-1:0] active_reg;
    logic [RECW-1:0]  mem [SLOTS];
    logic [RECW-1:0]  rd_reg;
    logic [IW:0]      idx_reg;
    logic [5:0]       slot_reg;
    logic [1:0]       shape_reg;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg;
    logic [EW-1:0]    ex_reg, ey_reg, ez_reg;
    logic [LAYER_BITS-1:0] layer_reg, mask_reg;
    logic [6:0]       limit_reg, nhit_reg;
    logic [2:0]       op_reg;
    logic             live_reg;

    logic             pv_reg;
    logic [5:0]       ph_reg;
    logic             any_reg;

    logic             ov_reg;
    logic [5:0]       oh_reg;
    logic [CW-1:0]    ox_reg, oy_reg, oz_reg;
    logic [1:0]       os_reg;
    logic             ol_reg;

    logic [1:0]            r_shape;
    logic signed [CW-1:0]  r_px, r_py, r_pz;
    logic [EW-1:0]         r_ex, r_ey, r_ez;
    logic [LAYER_BITS-1:0] r_layer, r_mask;
    assign {r_shape, r_px, r_py, r_pz, r_ex, r_ey, r_ez, r_layer, r_mask} = rd_reg;

    logic [IW-1:0] idx;
    assign idx = idx_reg[IW-1:0];
    logic slot_ok;
    assign slot_ok = (32'(slot_reg) < SLOTS);
    logic [IW-1:0] slot_i;
    assign slot_i = IW'(slot_reg);
    logic slot_op;
    assign slot_op = (op_reg == OP_REM) || (op_reg == OP_SETP) || (op_reg == OP_GETP);

    assign op = opcode_t'(op_reg);

    function automatic logic [DW-1:0] gapf(input logic signed [CW-1:0] p,
                                           input logic signed [CW-1:0] c,
                                           input logic [EW-1:0] h);
        logic signed [DW+1:0] lo, hi, pp;
        lo = (DW+2)'(c) - (DW+2)'(h);
        hi = (DW+2)'(c) + (DW+2)'(h);
        pp = (DW+2)'(p);
        if (pp < lo) return DW'(lo - pp);
        if (pp > hi) return DW'(pp - hi);
        return '0;
    endfunction

    // Overlap test stage, evaluated on the registered entry.
    logic [EW-1:0] hx, hy, hz;
    logic [DW-1:0] rr, dx, dy, dz;
    logic          valid_shape;
    logic [SW-1:0] ssum, rr2;
    logic          hit;
    always_comb begin
        hx = '0;
        hy = '0;
        hz = '0;
        rr = DW'(ex_reg);
        valid_shape = 1'b1;
        case (r_shape)
            SH_BOX: begin
                hx = r_ex;
                hy = r_ey;
                hz = r_ez;
            end
            SH_SPHERE: rr = DW'(ex_reg) + DW'(r_ex);
            SH_CAPSULE: begin
                hy = r_ey;
                rr = DW'(ex_reg) + DW'(r_ex);
            end
            default: valid_shape = 1'b0;
        endcase
        dx = gapf(px_reg, r_px, hx);
        dy = gapf(py_reg, r_py, hy);
        dz = gapf(pz_reg, r_pz, hz);
        ssum = SW'(dx) * SW'(dx) + SW'(dy) * SW'(dy) + SW'(dz) * SW'(dz);
        rr2 = SW'(rr) * SW'(rr);
        hit = valid_shape && active_reg[idx] && ((r_layer & mask_reg) != '0)
              && (dx <= rr) && (dy <= rr) && (dz <= rr) && (ssum <= rr2);
    end

    assign sts.scan_free = !idx_reg[IW] && !active_reg[idx];
    assign sts.scan_done = (32'(idx_reg) >= SLOTS - 1) || idx_reg[IW];
    assign sts.q_hit = hit;
    assign sts.q_done = (32'(idx_reg) >= SLOTS) || (nhit_reg >= limit_reg);
    assign sts.any_hit = any_reg;
    assign sts.pend_hit = pv_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg <= in_op;
            slot_reg <= in_slot;
            shape_reg <= in_shape;
            px_reg <= in_px;
            py_reg <= in_py;
            pz_reg <= in_pz;
            ex_reg <= in_ex;
            ey_reg <= in_ey;
            ez_reg <= in_ez;
            layer_reg <= in_layer;
            mask_reg <= in_mask;
            limit_reg <= (in_limit > 7'(MAX_HITS)) ? 7'(MAX_HITS) : in_limit;
        end
        if (cmd.rd_issue) begin
            rd_reg <= mem[IW'(in_slot)];
        end else if (slot_op) begin
            rd_reg <= mem[slot_i];
        end else begin
            rd_reg <= mem[idx];
        end
        if (cmd.add_write && sts.scan_free) begin
            mem[idx] <= {shape_reg, px_reg, py_reg, pz_reg, ex_reg, ey_reg, ez_reg,
                         layer_reg, mask_reg};
        end else if (cmd.do_setp && live_reg) begin
            mem[slot_i] <= {rd_reg[RECW-1 -: 2], px_reg, py_reg, pz_reg,
                            rd_reg[RECW-3-3*CW:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            idx_reg <= '0;
            nhit_reg <= '0;
            live_reg <= 1'b0;
            pv_reg <= 1'b0;
            any_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            live_reg <= slot_ok && active_reg[slot_i];
            if (cmd.clear_all) active_reg <= '0;
            if (cmd.scan_start || cmd.q_start) begin
                idx_reg <= '0;
                nhit_reg <= '0;
                any_reg <= 1'b0;
                pv_reg <= 1'b0;
            end
            if (cmd.clear_all || cmd.rd_issue) any_reg <= 1'b0;
            if (cmd.scan_step || cmd.q_step) idx_reg <= idx_reg + 1'b1;
            if (cmd.add_write && sts.scan_free) active_reg[idx] <= 1'b1;
            if (cmd.do_remove && live_reg) active_reg[slot_i] <= 1'b0;
            if (out_fire) ov_reg <= 1'b0;
            if (cmd.clear_all) begin
                ov_reg <= 1'b1;
                oh_reg <= '0;
                os_reg <= ST_OK;
                {ox_reg, oy_reg, oz_reg} <= '0;
                ol_reg <= 1'b1;
            end
            if (cmd.add_write) begin
                ov_reg <= 1'b1;
                oh_reg <= sts.scan_free ? 6'(idx) : 6'd0;
                os_reg <= sts.scan_free ? ST_OK : ST_FULL;
                {ox_reg, oy_reg, oz_reg} <= '0;
                ol_reg <= 1'b1;
            end
            if (cmd.res_load && !any_reg) begin
                ov_reg <= 1'b1;
                oh_reg <= slot_reg;
                os_reg <= live_reg ? ST_OK : ST_INACT;
                ol_reg <= 1'b1;
                if (op_reg == OP_GETP && live_reg) begin
                    ox_reg <= r_px;
                    oy_reg <= r_py;
                    oz_reg <= r_pz;
                end else begin
                    {ox_reg, oy_reg, oz_reg} <= '0;
                end
            end
            if (cmd.res_load && any_reg) begin
                // Flush the held hit as the final one.
                ov_reg <= 1'b1;
                oh_reg <= ph_reg;
                os_reg <= ST_OK;
                {ox_reg, oy_reg, oz_reg} <= '0;
                ol_reg <= 1'b1;
                pv_reg <= 1'b0;
            end
            if (cmd.res_nohit) begin
                ov_reg <= 1'b1;
                oh_reg <= '0;
                os_reg <= ST_NOHIT;
                {ox_reg, oy_reg, oz_reg} <= '0;
                ol_reg <= 1'b1;
            end
            if (cmd.res_hit) begin
                // A hit is held until the next one shows it was not the last.
                if (pv_reg) begin
                    ov_reg <= 1'b1;
                    oh_reg <= ph_reg;
                    os_reg <= ST_OK;
                    {ox_reg, oy_reg, oz_reg} <= '0;
                    ol_reg <= 1'b0;
                end
                pv_reg <= 1'b1;
                ph_reg <= 6'(idx);
                any_reg <= 1'b1;
                nhit_reg <= nhit_reg + 1'b1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_handle = oh_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_z = oz_reg;
    assign out_status = os_reg;
    assign out_last = ol_reg;

endmodule

// ===== sv/collider_table_sphere_overlap_query.sv =====
// ----------------------------------------------------------------------------
// collider_table_sphere_overlap_query
// Collider table with box, sphere and capsule entries and a sphere query.
// ----------------------------------------------------------------------------
// One command word enters on the s_ channel; its results leave on the m_
// channel, the final result of each command marked by m_axis_tlast.
// Add scans slots from zero, one per cycle. Remove, set and get position go
// through the registered entry memory read. A query reads one entry in
// S_QRD and tests it in S_QTEST, through the single memory read port.
// Hits leave one behind the scan, since each hit is held until the next
// one shows whether it is the last.
// One command is processed at a time. If the receiver stalls, the query
// halts on its next hit until the output register frees.
// Reset clears all valid bits and the controller; entry contents are not
// cleared and are read only after an add writes them.
// ----------------------------------------------------------------------------
module collider_table_sphere_overlap_query import ctsq_pkg::*; #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 24,
    parameter int LAYER_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // opcode, slot, shape_kind, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z,
    // layer_bits, mask_bits, limit
    input  logic [((11 + 3*COORD_BITS + 3*(COORD_BITS-1) + 2*LAYER_BITS + 7 + 7)/8)*8-1:0]
                 s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // handle, out_x, out_y, out_z, status
    output logic [((8 + 3*COORD_BITS + 7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS - 1;
    localparam int OW = ((8 + 3*CW + 7)/8)*8;

    logic in_fire, out_fire, in_ready;
    cmd_t cmd;
    sts_t sts;
    opcode_t op;
    logic [5:0] handle;
    logic signed [CW-1:0] ox, oy, oz;
    logic [1:0] status;

    assign s_axis_tready = in_ready;
    assign in_fire = s_axis_tvalid && in_ready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ctsq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .op(in_fire ? opcode_t'(s_axis_tdata[2:0]) : op),
        .out_busy(m_axis_tvalid && !m_axis_tready), .out_fire(out_fire),
        .sts(sts), .in_ready(in_ready), .cmd(cmd)
    );

    ctsq_dp #(.SLOTS(SLOTS), .COORD_BITS(COORD_BITS), .LAYER_BITS(LAYER_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_op(s_axis_tdata[2:0]),
        .in_slot(s_axis_tdata[8:3]),
        .in_shape(s_axis_tdata[10:9]),
        .in_px(s_axis_tdata[11 +: CW]),
        .in_py(s_axis_tdata[11+CW +: CW]),
        .in_pz(s_axis_tdata[11+2*CW +: CW]),
        .in_ex(s_axis_tdata[11+3*CW +: EW]),
        .in_ey(s_axis_tdata[11+3*CW+EW +: EW]),
        .in_ez(s_axis_tdata[11+3*CW+2*EW +: EW]),
        .in_layer(s_axis_tdata[11+3*CW+3*EW +: LAYER_BITS]),
        .in_mask(s_axis_tdata[11+3*CW+3*EW+LAYER_BITS +: LAYER_BITS]),
        .in_limit(s_axis_tdata[11+3*CW+3*EW+2*LAYER_BITS +: 7]),
        .cmd(cmd), .sts(sts), .op(op), .out_fire(out_fire),
        .out_valid(m_axis_tvalid), .out_handle(handle),
        .out_x(ox), .out_y(oy), .out_z(oz),
        .out_status(status), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = OW'({status, oz, oy, ox, handle});

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_onecmd: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_axis_tdata[2:0] <= OP_QUERY) |=> !s_axis_tready)
        else $error("second command accepted while busy");
    a_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[7+3*CW:6+3*CW] == ST_NOHIT) |-> m_axis_tlast)
        else $error("no-hit result not final");

endmodule
